FILE: rtl/mmvd_pkg.sv
// shared types, codes and constants of the multi-metric vector distance block
// no dependencies
`default_nettype none

package mmvd_pkg;

	localparam int MAX_COLUMNS_DEF = 65536;

	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;

	// shift-subtract step counts: divides take 64 dividend bits plus fraction bits; STEPS_SQRT is for the square root
	localparam logic [6:0] STEPS_Q0  = 7'd64;
	localparam logic [6:0] STEPS_Q16 = 7'd80;
	localparam logic [6:0] STEPS_Q31 = 7'd95;
	localparam logic [6:0] STEPS_Q32 = 7'd96;
	localparam logic [6:0] STEPS_SQRT = 7'd48;

	typedef enum logic [2:0] {
		M_MANHATTAN  = 3'd0,
		M_EUCLIDEAN  = 3'd1,
		M_CANBERRA   = 3'd2,
		M_BRAY       = 3'd3,
		M_KULCZYNSKI = 3'd4,
		M_GOWER      = 3'd5,
		M_MAXIMUM    = 3'd6,
		M_BINARY     = 3'd7
	} metric_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_INFINITE = 2'd2,
		ST_DIVZERO  = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b000_0001,
		S_ACC   = 7'b000_0010,
		S_SQADD = 7'b000_0100,
		S_DIV   = 7'b000_1000,
		S_SQRT  = 7'b001_0000,
		S_FINAL = 7'b010_0000,
		S_DONE  = 7'b100_0000
	} state_t;

	typedef enum logic [1:0] {
		DU_TERM = 2'd0,
		DU_FIN  = 2'd1,
		DU_K1   = 2'd2,
		DU_K2   = 2'd3
	} div_use_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] x,
		input logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63]) begin
			return s[64] ? INT64_MIN : INT64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/multi_metric_vector_distance.sv
// multi-metric vector distance: accumulators, sequencer and shared shift-subtract unit
// depends on mmvd_pkg
//
// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  first_value, second_value, first_finite,
//                                         second_finite, last_column
// out       source     out_valid/out_stall distance, result_status
// cfg       sink       cfg_write_en       cfg_write_data (metric_mode)
//
// an item is accepted in S_IDLE and accumulated in S_ACC; euclidean squares there, then
// adds in S_SQADD; a canberra pair with positive denominator also divides (S_DIV) in Q.32
// a last column adds the final step S_FINAL, then a divide for canberra, bray, gower and
// binary, two for kulczynski, the square root for euclidean; S_DONE loads the output
// reset clears mode and accumulators at once; no clearing pass
// a result waits in its own register while out_valid and out_stall are both high; the
// next item is taken only once the result has been moved into the output register
`default_nettype none

module multi_metric_vector_distance
	import mmvd_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic [2:0]         cfg_write_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] first_value,
	input  wire logic signed [31:0] second_value,
	input  wire logic               first_finite,
	input  wire logic               second_finite,
	input  wire logic               last_column,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      distance,
	output logic [1:0]              result_status
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_COLUMNS);

	state_t  state_q;
	metric_t mode_q;

	// item registers
	logic signed [31:0] a_q, b_q;
	logic [31:0]        diff_q;
	logic               usable_q, last_q;
	logic [63:0]        prod_q;

	// accumulators
	logic signed [63:0] primary_q, first_tot_q, second_tot_q;
	logic [31:0]        gap_q;
	logic [CW-1:0]      cnt_q;
	logic               inf_q;

	// shared shift-subtract unit state
	logic [63:0] num_q, den_q, quo_q;
	logic [64:0] rem_q;
	logic        ovf_q, neg_q;
	logic [6:0]  step_q, steps_q;
	div_use_t    use_q;

	logic signed [63:0] h1_q;
	logic signed [63:0] res_dist_q;
	status_t            res_stat_q;
	logic               out_valid_q;

	logic [64:0] sub_a, sub_b;
	logic [65:0] sub_d;
	logic        sub_ge;

	// compare-subtract shared by divide and square root
	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {rem_q[62:0], num_q[63:62]};
			sub_b = {quo_q[62:0], 2'b01};
		end else begin
			sub_a = {rem_q[63:0], num_q[63]};
			sub_b = {1'b0, den_q};
		end
		sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = ~sub_d[65];
	end

	logic [63:0]        div_mag;
	logic signed [63:0] div_res;
	assign div_mag = (ovf_q | quo_q[63]) ? INT64_MAX : quo_q;
	assign div_res = neg_q ? (64'sd0 - signed'(div_mag)) : signed'(div_mag);

	// accumulate-cycle decode
	logic               counted, take;
	logic signed [32:0] ab_sum;
	logic signed [31:0] min_ab;
	logic [63:0]        cnt_ext;
	logic signed [63:0] bray_total;
	logic signed [32:0] in_diff;

	assign counted = (mode_q == M_CANBERRA || mode_q == M_BINARY) ?
		(a_q != 32'sd0 || b_q != 32'sd0) : 1'b1;
	assign take    = usable_q && counted && (cnt_q < MAXC);
	assign ab_sum  = {a_q[31], a_q} + {b_q[31], b_q};
	assign min_ab  = (a_q < b_q) ? a_q : b_q;
	assign cnt_ext = {{(64-CW){1'b0}}, cnt_q};
	assign bray_total = sat_add64(first_tot_q, second_tot_q);
	assign in_diff = {first_value[31], first_value} - {second_value[31], second_value};

	// saturating left shift by 16 for manhattan
	logic signed [63:0] shl16;
	always_comb begin
		if (primary_q[63:47] == 17'h0 || primary_q[63:47] == 17'h1FFFF) begin
			shl16 = {primary_q[47:0], 16'h0};
		end else if (primary_q[63]) begin
			shl16 = 64'sd0 - INT64_MAX;
		end else begin
			shl16 = INT64_MAX;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_MANHATTAN;
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			primary_q   <= '0;
			first_tot_q <= '0;
			second_tot_q <= '0;
			gap_q       <= '0;
			cnt_q       <= '0;
			inf_q       <= 1'b0;
			num_q       <= '0;
			den_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			step_q      <= '0;
			steps_q     <= '0;
			use_q       <= DU_TERM;
			h1_q        <= '0;
			res_dist_q  <= '0;
			res_stat_q  <= ST_VALID;
		end else begin
			if (cfg_write_en) begin
				mode_q <= metric_t'(cfg_write_data);
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ACC;
					end
				end

				S_ACC: begin
					state_q <= last_q ? S_FINAL : S_IDLE;
					if (take) begin
						cnt_q <= cnt_q + 1'b1;
						case (mode_q)
							M_EUCLIDEAN: begin
								state_q <= S_SQADD;
							end
							M_CANBERRA: begin
								if (ab_sum > 33'sd0) begin
									// term = diff / (a+b) in Q.32
									num_q   <= {32'h0, diff_q};
									den_q   <= {{31{1'b0}}, ab_sum};
									neg_q   <= 1'b0;
									rem_q   <= '0;
									quo_q   <= '0;
									ovf_q   <= 1'b0;
									step_q  <= '0;
									steps_q <= STEPS_Q32;
									use_q   <= DU_TERM;
									state_q <= S_DIV;
								end else begin
									inf_q <= 1'b1;
								end
							end
							M_BRAY: begin
								primary_q    <= sat_add64(primary_q, {32'h0, diff_q});
								first_tot_q  <= sat_add64(first_tot_q, 64'(a_q));
								second_tot_q <= sat_add64(second_tot_q, 64'(b_q));
							end
							M_KULCZYNSKI: begin
								primary_q    <= sat_add64(primary_q, 64'(min_ab));
								first_tot_q  <= sat_add64(first_tot_q, 64'(a_q));
								second_tot_q <= sat_add64(second_tot_q, 64'(b_q));
							end
							M_MAXIMUM: begin
								if (diff_q > gap_q) begin
									gap_q <= diff_q;
								end
							end
							M_BINARY: begin
								if (a_q == 32'sd0 || b_q == 32'sd0) begin
									primary_q <= sat_add64(primary_q, 64'sd1);
								end
							end
							default: begin
								primary_q <= sat_add64(primary_q, {32'h0, diff_q});
							end
						endcase
					end
				end

				S_SQADD: begin
					// squares at or above 2^63 cap before the add
					primary_q <= sat_add64(primary_q, prod_q[63] ? INT64_MAX : prod_q);
					state_q   <= last_q ? S_FINAL : S_IDLE;
				end

				S_DIV: begin
					if (step_q == steps_q) begin
						case (use_q)
							DU_TERM: begin
								primary_q <= sat_add64(primary_q, div_res);
								state_q   <= last_q ? S_FINAL : S_IDLE;
							end
							DU_K1: begin
								h1_q    <= sat_add64(ONE_Q32, 64'sd0 - div_res);
								num_q   <= mag64(primary_q);
								den_q   <= mag64(second_tot_q);
								neg_q   <= primary_q[63] ^ second_tot_q[63];
								rem_q   <= '0;
								quo_q   <= '0;
								ovf_q   <= 1'b0;
								step_q  <= '0;
								steps_q <= STEPS_Q31;
								use_q   <= DU_K2;
							end
							DU_K2: begin
								res_dist_q <= sat_add64(h1_q, 64'sd0 - div_res);
								res_stat_q <= ST_VALID;
								state_q    <= S_DONE;
							end
							default: begin
								res_dist_q <= div_res;
								res_stat_q <= ST_VALID;
								state_q    <= S_DONE;
							end
						endcase
					end else begin
						rem_q  <= sub_ge ? sub_d[64:0] : sub_a;
						quo_q  <= {quo_q[62:0], sub_ge};
						ovf_q  <= ovf_q | quo_q[63];
						num_q  <= {num_q[62:0], 1'b0};
						step_q <= step_q + 1'b1;
					end
				end

				S_SQRT: begin
					if (step_q == steps_q) begin
						res_dist_q <= signed'(quo_q);
						res_stat_q <= ST_VALID;
						state_q    <= S_DONE;
					end else begin
						rem_q  <= sub_ge ? sub_d[64:0] : sub_a;
						quo_q  <= {quo_q[62:0], sub_ge};
						num_q  <= {num_q[61:0], 2'b00};
						step_q <= step_q + 1'b1;
					end
				end

				S_FINAL: begin
					res_dist_q <= '0;
					res_stat_q <= ST_VALID;
					state_q    <= S_DONE;
					// common divide setup: primary sum over the chosen denominator
					num_q  <= mag64(primary_q);
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
					step_q <= '0;
					use_q  <= DU_FIN;
					if (cnt_q == '0) begin
						res_stat_q <= ST_EMPTY;
					end else begin
						case (mode_q)
							M_EUCLIDEAN: begin
								// negative sum from a mode change counts as zero
								num_q   <= primary_q[63] ? 64'h0 : primary_q;
								steps_q <= STEPS_SQRT;
								state_q <= S_SQRT;
							end
							M_CANBERRA: begin
								if (inf_q) begin
									res_stat_q <= ST_INFINITE;
									res_dist_q <= INT64_MAX;
								end else begin
									den_q   <= cnt_ext;
									neg_q   <= primary_q[63];
									steps_q <= STEPS_Q0;
									state_q <= S_DIV;
								end
							end
							M_BRAY: begin
								if (bray_total == 64'sd0) begin
									res_stat_q <= ST_DIVZERO;
								end else begin
									den_q   <= mag64(bray_total);
									neg_q   <= primary_q[63] ^ bray_total[63];
									steps_q <= STEPS_Q32;
									state_q <= S_DIV;
								end
							end
							M_KULCZYNSKI: begin
								if (first_tot_q == 64'sd0 || second_tot_q == 64'sd0) begin
									res_stat_q <= ST_DIVZERO;
								end else begin
									den_q   <= mag64(first_tot_q);
									neg_q   <= primary_q[63] ^ first_tot_q[63];
									steps_q <= STEPS_Q31;
									use_q   <= DU_K1;
									state_q <= S_DIV;
								end
							end
							M_GOWER: begin
								den_q   <= cnt_ext;
								neg_q   <= primary_q[63];
								steps_q <= STEPS_Q16;
								state_q <= S_DIV;
							end
							M_MAXIMUM: begin
								res_dist_q <= {16'h0, gap_q, 16'h0};
							end
							M_BINARY: begin
								den_q   <= cnt_ext;
								neg_q   <= primary_q[63];
								steps_q <= STEPS_Q32;
								state_q <= S_DIV;
							end
							default: begin
								res_dist_q <= shl16;
							end
						endcase
					end
				end

				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						primary_q    <= '0;
						first_tot_q  <= '0;
						second_tot_q <= '0;
						gap_q        <= '0;
						cnt_q        <= '0;
						inf_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			a_q      <= first_value;
			b_q      <= second_value;
			diff_q   <= in_diff[32] ? 32'(33'sd0 - in_diff) : in_diff[31:0];
			usable_q <= first_finite & second_finite;
			last_q   <= last_column;
		end
		if (state_q == S_ACC) begin
			prod_q <= diff_q * diff_q;
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			distance      <= res_dist_q;
			result_status <= res_stat_q;
		end
	end

	// count never passes the column limit
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= MAXC)
		else $error("usable count above column limit");

	// an accepted item is accumulated in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_ACC))
		else $error("accepted item not accumulated");

	// the shift-subtract unit never runs past its step count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_SQRT) |-> (step_q <= steps_q))
		else $error("shift-subtract step overrun");

	// an infinite result always carries the largest distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_status == ST_INFINITE) |-> (distance == INT64_MAX))
		else $error("infinite status with wrong distance");

endmodule

`default_nettype wire
